// ===== rtl/core/lkc_pkg.sv =====
// Shared constants, types and a helper function for the LRU key cache.
`timescale 1ns / 1ps

package lkc_pkg;

	// Storage geometry
	localparam int MAX_ENTRIES = 8;
	localparam int KEY_WIDTH   = 32;

	// Derived widths
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int RANK_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

	// Capacity register
	localparam int CAP_W = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_key;
		logic lookup;
		logic commit;
	} cmd_t;

	// Index of the lowest set bit; zero when none is set
	function automatic logic [IDX_W-1:0] first_set(input logic [MAX_ENTRIES-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/core/lkc_if.sv =====
// Request, result and capacity-write channel interfaces of the LRU key cache.
`timescale 1ns / 1ps

interface lkc_req_if;
	import lkc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] key;
	modport source (output valid, output key, input ready);
	modport sink (input valid, input key, output ready);
endinterface

interface lkc_res_if;
	import lkc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 evicted;
	logic [KEY_WIDTH-1:0] evicted_key;
	logic [CNT_W-1:0]     occupancy;
	modport source (output valid, output hit, output evicted, output evicted_key,
		output occupancy, input ready);
	modport sink (input valid, input hit, input evicted, input evicted_key,
		input occupancy, output ready);
endinterface

interface lkc_cfg_if;
	import lkc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;
	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

// ===== rtl/core/lkc_ctrl.sv =====
// Sequencing state machine of the LRU key cache: accept, look up, commit.
`timescale 1ns / 1ps

module lkc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          res_valid,
	input  logic          res_ready,
	output lkc_pkg::cmd_t cmd
);
	import lkc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_key = 1'b1;
					state_d      = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				// Commit only when the result register is free or drains now
				if (!out_valid_q || res_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Track the result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;

endmodule

// ===== rtl/core/lkc_dp.sv =====
// Datapath of the LRU key cache: entry store, recency ranks, lookup and result register.
`timescale 1ns / 1ps

module lkc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkc_pkg::cmd_t                 cmd,
	input  logic [lkc_pkg::KEY_WIDTH-1:0] req_key,
	input  logic                          cfg_we,
	input  logic [lkc_pkg::CAP_W-1:0]     cfg_capacity,
	output logic                          res_hit,
	output logic                          res_evicted,
	output logic [lkc_pkg::KEY_WIDTH-1:0] res_evicted_key,
	output logic [lkc_pkg::CNT_W-1:0]     res_occupancy
);
	import lkc_pkg::*;

	// Entry store and replacement state
	logic [KEY_WIDTH-1:0]   keys_q  [MAX_ENTRIES];
	logic [RANK_W-1:0]      rank_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [CAP_W-1:0]       capacity_q;

	// Request key and lookup decision
	logic [KEY_WIDTH-1:0] key_q;
	logic                 hit_q;
	logic                 evict_q;
	logic [IDX_W-1:0]     slot_q;
	logic [RANK_W:0]      age_lim_q;

	// Lookup logic
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] is_lru;
	logic [RANK_W-1:0]      lru_rank;
	logic [CMP_W-1:0]       eff_cap;
	logic                   full;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;

	assign lru_rank = RANK_W'(count_q - CNT_W'(1));

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i]  = valid_q[i] && (keys_q[i] == key_q);
			is_lru[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
	end

	assign hit     = |match;
	assign hit_idx = first_set(match);

	// Clamp capacity to the range one to the number of entries
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CMP_W'(capacity_q);
		end
	end

	assign full = CMP_W'(count_q) >= eff_cap;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_capacity;
		end
	end

	// Latch the request key
	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= req_key;
		end
	end

	// Register the lookup outcome: hit and eviction flags, target slot and aging limit
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q   <= hit;
			evict_q <= !hit && full;
			if (hit) begin
				slot_q    <= hit_idx;
				age_lim_q <= {1'b0, rank_q[hit_idx]};
			end else begin
				slot_q    <= full ? first_set(is_lru) : first_set(~valid_q);
				age_lim_q <= (RANK_W + 1)'(MAX_ENTRIES);
			end
		end
	end

	// Age ranks and place the accessed key as most recent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IDX_W'(i) == slot_q) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && ({1'b0, rank_q[i]} < age_lim_q)) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
			valid_q[slot_q] <= 1'b1;
			if (!hit_q && !evict_q) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Write the new key into its slot on a miss
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_q) begin
			keys_q[slot_q] <= key_q;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_hit         <= hit_q;
			res_evicted     <= evict_q;
			res_evicted_key <= evict_q ? keys_q[slot_q] : '0;
			res_occupancy   <= (!hit_q && !evict_q) ? count_q + CNT_W'(1) : count_q;
		end
	end

endmodule

// ===== rtl/core/lru_key_cache.sv =====
// Top level of the LRU key cache: channel ports, controller and datapath.
`timescale 1ns / 1ps

// Fully associative cache of up to MAX_ENTRIES keys with least-recently-used
// replacement. Each request carries one key and yields one result: hit, whether
// an entry was evicted, the evicted key (zero when none) and the occupancy after
// the access. A request passes through three steps (accept, parallel lookup,
// commit), and the block works on one request at a time, while a finished result
// may wait in the output register as the next request is accepted. Capacity is
// to be written through the configuration channel only while the block is idle;
// the block itself does not enforce this. Zero acts as one and values above
// MAX_ENTRIES act as MAX_ENTRIES. No clearing pass is needed after reset.
module lru_key_cache (
	input logic       clk,
	input logic       arst_n,
	lkc_req_if.sink   req,
	lkc_res_if.source res,
	lkc_cfg_if.sink   cfg
);
	import lkc_pkg::*;

	cmd_t cmd;

	assign cfg.ready = 1'b1;

	lkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cmd       (cmd)
	);

	lkc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_key         (req.key),
		.cfg_we          (cfg.valid),
		.cfg_capacity    (cfg.capacity),
		.res_hit         (res.hit),
		.res_evicted     (res.evicted),
		.res_evicted_key (res.evicted_key),
		.res_occupancy   (res.occupancy)
	);

`ifndef SYNTHESIS
	// Commit never overwrites an undelivered result
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!res.valid || res.ready))
		else $error("commit while result register is occupied");

	// One request at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// A hit never evicts, and a result without eviction reports a zero key
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!(res.hit && res.evicted) && (res.evicted || res.evicted_key == '0)))
		else $error("inconsistent hit and eviction result");

	// Occupancy stays within the entry count
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.occupancy <= CNT_W'(MAX_ENTRIES)))
		else $error("occupancy exceeds number of entries");
`endif

endmodule
